[rtl/nnss_pkg.sv]
// Shared constants, types and helper functions for the nearest-neighbor sprite scaler.
// No dependencies; every other file of the block imports this package.
package nnss_pkg;

	localparam int OUT_SIZE     = 24;
	localparam int MAX_SRC      = 128;
	localparam int COORD_W      = 7;
	localparam int SIZE_W       = 8;
	localparam int ADDR_W       = 2 * COORD_W;
	localparam int XCOL_W       = 5;
	localparam int PIX_W        = 16;
	localparam int CHAN_W       = 8;
	localparam int DEFAULT_SIZE = 24;

	// Division by OUT_SIZE is done as a shift by three and a reciprocal multiply by
	// three, which is exact for every dividend that can occur here.
	localparam int DIV3_MUL   = 683;
	localparam int DIV3_SHIFT = 11;
	localparam int DIV8_SHIFT = 3;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;
	localparam int FIFO_CNT_W = 3;

	localparam logic CFG_SRC_WIDTH  = 1'b0;
	localparam logic CFG_SRC_HEIGHT = 1'b1;

	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_RENDER = 1'b1;

	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] addr;
		logic [XCOL_W-1:0] column;
		logic              last;
	} rd_req_t;

	typedef struct packed {
		logic [PIX_W-1:0]  argb;
		logic [XCOL_W-1:0] column;
		logic              last;
	} out_item_t;

	function automatic logic [SIZE_W-1:0] effective_size(input logic [SIZE_W-1:0] value);
		logic [SIZE_W-1:0] res;
		res = value;
		if (value == '0) begin
			res = SIZE_W'(1);
		end else if (value > SIZE_W'(MAX_SRC)) begin
			res = SIZE_W'(MAX_SRC);
		end
		return res;
	endfunction

	function automatic logic [PIX_W-1:0] pack_pixel(input logic [CHAN_W-1:0] a,
			input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
			input logic [CHAN_W-1:0] b);
		return {a[7:4], r[7:4], g[7:4], b[7:4]};
	endfunction

	// Quotient of a 9-bit value by three, truncated to COORD_W bits.
	function automatic logic [COORD_W-1:0] div3(input logic [8:0] value);
		logic [18:0] prod;
		prod = 19'(value) * 19'(DIV3_MUL);
		return COORD_W'(prod >> DIV3_SHIFT);
	endfunction

endpackage

[rtl/nnss_frame_mem.sv]
// Source frame store: one write port and one read port, read data registered.
// Depends on nnss_pkg for the address and pixel widths.
module nnss_frame_mem import nnss_pkg::*; (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [PIX_W-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [PIX_W-1:0]  rdata
);

	logic [PIX_W-1:0] mem [MAX_SRC*MAX_SRC];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/nnss_row_seq.sv]
// Render sequencer: computes the source row once, then steps the source column
// incrementally and issues one frame store read per target column.
// Depends on nnss_pkg for sizes, the read request type and the divide helper.
module nnss_row_seq import nnss_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [XCOL_W-1:0] start_row,
	input  logic [SIZE_W-1:0] w_eff,
	input  logic [SIZE_W-1:0] h_eff,
	input  logic              issue_ok,
	output rd_req_t           rd_req,
	output logic              busy
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SETUP1 = 2'd1;
	localparam logic [1:0] ST_SETUP2 = 2'd2;
	localparam logic [1:0] ST_RUN    = 2'd3;

	localparam logic [XCOL_W-1:0] LAST_X = XCOL_W'(OUT_SIZE - 1);

	logic [1:0]         state_q;
	logic [XCOL_W-1:0]  row_q;
	logic [12:0]        prod_q;
	logic [2:0]         k_q;
	logic [COORD_W-1:0] sy_q;
	logic [XCOL_W-1:0]  r_q;
	logic [XCOL_W-1:0]  x_q;
	logic [COORD_W-1:0] sx_q;
	logic [XCOL_W-1:0]  rem_q;

	logic [XCOL_W:0]    rem_sum;
	logic               carry;
	logic [XCOL_W-1:0]  rem_next;
	logic [COORD_W-1:0] sx_next;
	logic               issue;

	// Column step: x*W/OUT = x*k + floor(x*r/OUT), with W = k*OUT + r.
	always_comb begin
		rem_sum  = (XCOL_W+1)'(rem_q) + (XCOL_W+1)'(r_q);
		carry    = rem_sum >= (XCOL_W+1)'(OUT_SIZE);
		rem_next = carry ? XCOL_W'(rem_sum - (XCOL_W+1)'(OUT_SIZE)) : XCOL_W'(rem_sum);
		sx_next  = sx_q + COORD_W'(k_q) + COORD_W'(carry);
	end

	assign issue         = (state_q == ST_RUN) && issue_ok;
	assign rd_req.valid  = issue;
	assign rd_req.addr   = {sy_q, sx_q};
	assign rd_req.column = x_q;
	assign rd_req.last   = x_q == LAST_X;
	assign busy          = state_q != ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_SETUP1;
					end
				end
				ST_SETUP1: state_q <= ST_SETUP2;
				ST_SETUP2: state_q <= ST_RUN;
				ST_RUN: begin
					if (issue && (x_q == LAST_X)) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			row_q <= start_row;
		end
		if (state_q == ST_SETUP1) begin
			prod_q <= 13'(row_q) * 13'(h_eff);
			k_q    <= 3'(div3(9'(w_eff >> DIV8_SHIFT)));
		end
		if (state_q == ST_SETUP2) begin
			sy_q  <= div3(9'(prod_q >> DIV8_SHIFT));
			r_q   <= XCOL_W'(w_eff - SIZE_W'(k_q) * SIZE_W'(OUT_SIZE));
			x_q   <= '0;
			sx_q  <= '0;
			rem_q <= '0;
		end
		if (issue) begin
			x_q   <= x_q + XCOL_W'(1);
			sx_q  <= sx_next;
			rem_q <= rem_next;
		end
	end

endmodule

[rtl/nnss_out_fifo.sv]
// Four-entry result queue between the frame store read and the output channel.
// Depends on nnss_pkg for the result item type and queue sizes.
module nnss_out_fifo import nnss_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  out_item_t             push_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             head_item,
	output logic [FIFO_CNT_W-1:0] count
);

	out_item_t             store [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic                  pop;

	assign out_valid = cnt_q != '0;
	assign pop       = out_valid && out_ready;
	assign head_item = store[rd_ptr_q];
	assign count     = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + FIFO_CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - FIFO_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			store[wr_ptr_q] <= push_item;
		end
	end

endmodule

[rtl/nearest_neighbor_sprite_scaler.sv]
// Top level of the nearest-neighbor sprite scaler: request handshake, size registers,
// frame store, render sequencer and result queue. Depends on nnss_pkg and all rtl modules.
//
// The block holds a 128 x 128 source frame in a single 16-bit synchronous memory and
// rescales it to a 24 x 24 ARGB4444 image one target row at a time. A load request
// writes one pixel (only the top nibble of each channel is kept); loads outside the
// configured width and height are dropped. Loads stream at one per cycle while no
// render is busy. A render for a row below 24 holds the input channel busy until its
// last read issues: SETUP1 and SETUP2 compute the source row and column step, then
// one frame store read issues per target column, one per cycle while the queue has
// room, since the memory has a single read port. Results leave in column order
// through a four-entry queue, one per cycle while out_ready is held, and the last
// pixel of the row carries last. A render for row 24 or above is accepted and gives
// no result. The next request is taken while earlier results still drain. The frame
// store is not cleared at reset; a render must only read pixels that were loaded.
// Size registers reset to 24; the user must write them through the cfg port while
// the block is idle, which it does not enforce. A value of 0 acts as 1, above 128 as 128.
module nearest_neighbor_sprite_scaler import nnss_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// Configuration write port.
	input  logic               cfg_write,
	input  logic               cfg_index,
	input  logic [SIZE_W-1:0]  cfg_data,
	// Request channel.
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               action,
	input  logic [COORD_W-1:0] column,
	input  logic [COORD_W-1:0] row,
	input  logic [CHAN_W-1:0]  blue,
	input  logic [CHAN_W-1:0]  green,
	input  logic [CHAN_W-1:0]  red,
	input  logic [CHAN_W-1:0]  alpha,
	// Result channel.
	output logic               out_valid,
	input  logic               out_ready,
	output logic [PIX_W-1:0]   argb,
	output logic [XCOL_W-1:0]  out_column,
	output logic               last
);

	logic [SIZE_W-1:0]     src_width_q;
	logic [SIZE_W-1:0]     src_height_q;
	logic [SIZE_W-1:0]     w_eff;
	logic [SIZE_W-1:0]     h_eff;

	logic                  accept;
	logic                  mem_we;
	logic                  render_start;
	logic                  seq_busy;
	logic                  issue_ok;
	rd_req_t               rd_req;
	logic [PIX_W-1:0]      mem_rdata;

	logic                  rd_valid_s1;
	logic [XCOL_W-1:0]     rd_column_s1;
	logic                  rd_last_s1;

	out_item_t             push_item;
	out_item_t             head_item;
	logic [FIFO_CNT_W-1:0] fifo_cnt;

	// Size registers, written by index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= SIZE_W'(DEFAULT_SIZE);
			src_height_q <= SIZE_W'(DEFAULT_SIZE);
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_SRC_WIDTH:  src_width_q  <= cfg_data;
				CFG_SRC_HEIGHT: src_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign w_eff = effective_size(src_width_q);
	assign h_eff = effective_size(src_height_q);

	// Requests are taken whenever no render is in setup or stepping through its columns.
	assign in_ready = !seq_busy;
	assign accept   = in_valid && in_ready;

	// A load lands only inside the configured frame; the store stride stays at 128.
	assign mem_we = accept && (action == ACT_LOAD)
		&& (SIZE_W'(column) < w_eff) && (SIZE_W'(row) < h_eff);

	// Rows beyond the target image are accepted and give nothing.
	assign render_start = accept && (action == ACT_RENDER) && (row < COORD_W'(OUT_SIZE));

	// A read is issued only when the queue is sure to have room for it and for the
	// read still in flight, assuming no result leaves in the meantime.
	assign issue_ok = ((FIFO_CNT_W+1)'(fifo_cnt) + (FIFO_CNT_W+1)'(rd_valid_s1))
		< (FIFO_CNT_W+1)'(FIFO_DEPTH);

	nnss_row_seq u_row_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (render_start),
		.start_row (XCOL_W'(row)),
		.w_eff     (w_eff),
		.h_eff     (h_eff),
		.issue_ok  (issue_ok),
		.rd_req    (rd_req),
		.busy      (seq_busy)
	);

	// Loads and reads never share a cycle: loads are taken only while the sequencer
	// is idle, so the frame store needs no forwarding.
	nnss_frame_mem u_frame_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr ({row, column}),
		.wdata (pack_pixel(alpha, red, green, blue)),
		.re    (rd_req.valid),
		.raddr (rd_req.addr),
		.rdata (mem_rdata)
	);

	// Column tag travels alongside the registered memory read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_req.valid) begin
			rd_column_s1 <= rd_req.column;
			rd_last_s1   <= rd_req.last;
		end
	end

	assign push_item.argb   = mem_rdata;
	assign push_item.column = rd_column_s1;
	assign push_item.last   = rd_last_s1;

	nnss_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (rd_valid_s1),
		.push_item (push_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head_item (head_item),
		.count     (fifo_cnt)
	);

	assign argb       = head_item.argb;
	assign out_column = head_item.column;
	assign last       = head_item.last;

`ifndef SYNTH
	// The credit check must keep queued plus in-flight results within the queue.
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		((FIFO_CNT_W+1)'(fifo_cnt) + (FIFO_CNT_W+1)'(rd_valid_s1))
			<= (FIFO_CNT_W+1)'(FIFO_DEPTH))
		else $error("result queue credit exceeded");

	// The frame store is never asked to load and read in one cycle.
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && rd_req.valid))
		else $error("frame store load and read overlap");

	// The row-end marker only ever sits on the final target column.
	a_last_column: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last) |-> (out_column == XCOL_W'(OUT_SIZE - 1)))
		else $error("last marker on wrong column");

	// Every issued read reaches the queue in the following cycle.
	a_read_to_push: assert property (@(posedge clk) disable iff (!arst_n)
		rd_req.valid |=> rd_valid_s1)
		else $error("issued read did not reach the result queue");
`endif

endmodule
